// ----- sv/scratch_extremum_detector_core_macros.svh -----
// Assertion macros for the scratch extremum detector core.
// Used by the top level only; no other dependencies.
`ifndef SCRATCH_EXTREMUM_DETECTOR_CORE_MACROS_SVH
`define SCRATCH_EXTREMUM_DETECTOR_CORE_MACROS_SVH

// property that holds at every edge out of reset
`define SED_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SED_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sed_pkg.sv -----
// Shared types and constants of the scratch extremum detector.
// No dependencies.
package sed_pkg;

  localparam int SED_MAX_HALF_WIDTH = 16;
  localparam int SED_MAX_LINE_WIDTH = 4096;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ASYMMETRY = 2'd1;
  localparam logic [1:0] REG_MAIN_HW   = 2'd2;
  localparam logic [1:0] REG_REJ_HW    = 2'd3;

  localparam logic [8:0] THRESHOLD_RST = 9'd24;
  localparam logic [7:0] ASYMMETRY_RST = 8'd16;
  localparam logic [4:0] MAIN_HW_RST   = 5'd3;
  localparam logic [4:0] REJ_HW_RST    = 5'd1;

  typedef struct packed {
    logic signed [8:0] threshold;
    logic [7:0]        asymmetry;
    logic [4:0]        main_hw;
    logic [4:0]        rej_hw;
  } cfg_t;

  // samples around one candidate column
  typedef struct packed {
    logic [7:0] c;
    logic [7:0] l;
    logic [7:0] ll;
    logic [7:0] li;
    logic [7:0] r;
    logic [7:0] rr;
    logic [7:0] ri;
  } taps_t;

endpackage

// ----- sv/sed_stream_if.sv -----
// Valid/ready stream interfaces for input samples and result flags.
// No dependencies.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       end_of_line;

  modport source (output valid, sample, end_of_line, input ready);
  modport sink (input valid, sample, end_of_line, output ready);
endinterface

interface sed_out_if;
  logic valid;
  logic ready;
  logic extremum;
  logic last_of_run;

  modport source (output valid, extremum, last_of_run, input ready);
  modport sink (input valid, extremum, last_of_run, output ready);
endinterface

// ----- sv/sed_window.sv -----
// Sample shift line with tap selection for the main and rejection tests.
// Depends on sed_pkg.
module sed_window import sed_pkg::*; #(
  parameter int MAX_HALF_WIDTH = SED_MAX_HALF_WIDTH,
  localparam int HW_W = $clog2(MAX_HALF_WIDTH + 1)
) (
  input  logic            clk,
  input  logic            shift,
  input  logic [7:0]      sample,
  input  logic [HW_W-1:0] line_max,
  input  logic [HW_W-1:0] line_min,
  output taps_t           main_taps,
  output taps_t           min_taps
);

  localparam int WIN  = 2 * MAX_HALF_WIDTH + 3;
  localparam int IX_W = $clog2(WIN);

  logic [7:0]      win [WIN];
  logic [IX_W-1:0] d;
  logic [IX_W-1:0] m;

  always_ff @(posedge clk) begin
    if (shift) begin
      win[0] <= sample;
      for (int i = 1; i < WIN; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  assign d = IX_W'(line_max);
  assign m = IX_W'(line_min);

  // newest sample at index 0, candidate column at index d+1
  always_comb begin
    main_taps.c  = win[d + IX_W'(1)];
    main_taps.l  = win[d + d + IX_W'(1)];
    main_taps.ll = win[d + d + IX_W'(2)];
    main_taps.li = win[d + d];
    main_taps.r  = win[1];
    main_taps.rr = win[0];
    main_taps.ri = win[2];

    min_taps.c  = win[d + IX_W'(1)];
    min_taps.l  = win[d + m + IX_W'(1)];
    min_taps.ll = win[d + m + IX_W'(2)];
    min_taps.li = win[d + m];
    min_taps.r  = win[d + IX_W'(1) - m];
    min_taps.rr = win[d - m];
    min_taps.ri = win[d + IX_W'(2) - m];
  end

endmodule

// ----- sv/sed_sharp.sv -----
// Sharp narrow extremum test on one set of taps.
// Depends on sed_pkg.
module sed_sharp import sed_pkg::*; (
  input  taps_t taps,
  input  cfg_t  cfg,
  output logic  pass
);

  logic signed [10:0] c, l, ll, li, r, rr, ri;
  logic signed [10:0] asy, asy_abs, inner, outer, th, dl, dr;
  logic               dark;

  always_comb begin
    c  = signed'({3'b000, taps.c});
    l  = signed'({3'b000, taps.l});
    ll = signed'({3'b000, taps.ll});
    li = signed'({3'b000, taps.li});
    r  = signed'({3'b000, taps.r});
    rr = signed'({3'b000, taps.rr});
    ri = signed'({3'b000, taps.ri});
    th = signed'({{2{cfg.threshold[8]}}, cfg.threshold});

    asy     = ll - rr;
    asy_abs = asy[10] ? -asy : asy;
    inner   = (l - li) + (r - ri);
    outer   = (ll - l) + (rr - r);
    dl      = l - c;
    dr      = r - c;
    dark    = !cfg.threshold[8] && (cfg.threshold != '0);

    if (asy_abs > signed'({3'b000, cfg.asymmetry})) begin
      pass = 1'b0;
    end else if (dark) begin
      pass = (dl > th) && (dr > th) && (inner > outer);
    end else begin
      pass = (dl < th) && (dr < th) && (inner < outer);
    end
  end

endmodule

// ----- sv/sed_seq.sv -----
// Line sequencer: column count, per-line widths, item stage, flush and
// result register. Depends on sed_pkg and the stream interfaces.
module sed_seq import sed_pkg::*; #(
  parameter int MAX_HALF_WIDTH = SED_MAX_HALF_WIDTH,
  parameter int MAX_LINE_WIDTH = SED_MAX_LINE_WIDTH,
  localparam int HW_W = $clog2(MAX_HALF_WIDTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  sed_in_if.sink          in_ch,
  sed_out_if.source       out_ch,
  input  cfg_t            cfg,
  input  logic            main_pass,
  input  logic            min_pass,
  output logic            shift,
  output logic [HW_W-1:0] line_max,
  output logic [HW_W-1:0] line_min
);

  localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
  localparam int CMP_W = CNT_W + 2;
  localparam int FL_W  = $clog2(MAX_HALF_WIDTH + 2);
  localparam int CL_W  = 7;

  logic [CNT_W-1:0] col;
  logic             p_valid;
  logic             p_flag;
  logic             p_full;
  logic [FL_W-1:0]  p_flush;
  logic             out_valid;
  logic             out_ext;
  logic             out_last;

  logic [CL_W-1:0]  mw, mn, lim, dd, mm;
  logic [HW_W-1:0]  d_new, m_new, d_use;
  logic [CMP_W-1:0] n_ext, d_ext;
  logic             has_flag_new, full_new;
  logic [FL_W-1:0]  flush_new;
  logic             emit_ok, any_left, emit, last_one, p_done, flag_bit;

  // clamp the width registers for a new line
  always_comb begin
    mw  = CL_W'(cfg.main_hw);
    mn  = CL_W'(cfg.rej_hw);
    lim = CL_W'(MAX_HALF_WIDTH);
    dd  = (mw < CL_W'(1)) ? CL_W'(1) : mw;
    dd  = (dd > lim) ? lim : dd;
    mm  = (mn > lim) ? lim : mn;
    dd  = (dd < mm) ? mm : dd;
    d_new = HW_W'(dd);
    m_new = HW_W'(mm);
  end

  always_comb begin
    d_use        = (col == '0) ? d_new : line_max;
    n_ext        = CMP_W'(col);
    d_ext        = CMP_W'(d_use);
    has_flag_new = n_ext >= d_ext + CMP_W'(1);
    full_new     = n_ext >= d_ext + d_ext + CMP_W'(2);
    if (!in_ch.end_of_line) begin
      flush_new = '0;
    end else if (has_flag_new) begin
      flush_new = FL_W'(d_use) + FL_W'(1);
    end else begin
      flush_new = FL_W'(col) + FL_W'(1);
    end
  end

  always_comb begin
    emit_ok  = !out_valid || out_ch.ready;
    any_left = p_flag || (p_flush != '0);
    emit     = p_valid && any_left && emit_ok;
    last_one = (p_flag && p_flush == '0) || (!p_flag && p_flush == FL_W'(1));
    p_done   = p_valid && (!any_left || (emit && last_one));
    flag_bit = p_full && main_pass && !((line_min > HW_W'(1)) && min_pass);
  end

  assign in_ch.ready = !rst && (!p_valid || p_done);
  assign shift       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      line_max  <= '0;
      line_min  <= '0;
      p_valid   <= 1'b0;
      p_flag    <= 1'b0;
      p_full    <= 1'b0;
      p_flush   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (shift) begin
        p_valid <= 1'b1;
        p_flag  <= has_flag_new;
        p_full  <= full_new;
        p_flush <= flush_new;
        if (col == '0) begin
          line_max <= d_new;
          line_min <= m_new;
        end
        if (in_ch.end_of_line) begin
          col <= '0;
        end else if (col < CNT_W'(MAX_LINE_WIDTH - 1)) begin
          col <= col + CNT_W'(1);
        end
      end else if (p_done) begin
        p_valid <= 1'b0;
      end else if (emit) begin
        // own flag first, then the zero border beats
        if (p_flag) begin
          p_flag <= 1'b0;
        end else begin
          p_flush <= p_flush - FL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ext  <= p_flag ? flag_bit : 1'b0;
      out_last <= !p_flag && (p_flush == FL_W'(1));
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.extremum    = out_ext;
  assign out_ch.last_of_run = out_last;

endmodule

// ----- sv/scratch_extremum_detector_core.sv -----
// Top level of the scratch extremum detector: register file and datapath.
// Depends on sed_pkg, the stream interfaces, sed_window, sed_sharp, sed_seq.
//
//   channel  dir  beat payload                 handshake
//   in_ch    in   sample[7:0], end_of_line     valid/ready
//   out_ch   out  extremum, last_of_run        valid/ready
//   apb      in   threshold, asymmetry, widths psel/penable, pready=1
//
// One sample per cycle unless the result register stalls. An end-of-line
// sample holds the next input until its result beats, up to MAX_HALF_WIDTH+2,
// have left, moved one beat a cycle into the single result register.
// Synchronous reset clears control state; no clearing pass is needed.
// A stalled result register holds the sequencer and then the input.
`include "scratch_extremum_detector_core_macros.svh"

module scratch_extremum_detector_core import sed_pkg::*; #(
  parameter int MAX_HALF_WIDTH = SED_MAX_HALF_WIDTH,
  parameter int MAX_LINE_WIDTH = SED_MAX_LINE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  sed_in_if.sink            in_ch,
  sed_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int HW_W = $clog2(MAX_HALF_WIDTH + 1);

  cfg_t            cfg;
  logic            shift;
  logic [HW_W-1:0] line_max;
  logic [HW_W-1:0] line_min;
  taps_t           main_taps;
  taps_t           min_taps;
  logic            main_pass;
  logic            min_pass;
  logic            last_beat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= signed'(THRESHOLD_RST);
      cfg.asymmetry <= ASYMMETRY_RST;
      cfg.main_hw   <= MAIN_HW_RST;
      cfg.rej_hw    <= REJ_HW_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_THRESHOLD: cfg.threshold <= signed'(pwdata[8:0]);
        REG_ASYMMETRY: cfg.asymmetry <= pwdata[7:0];
        REG_MAIN_HW:   cfg.main_hw   <= pwdata[4:0];
        REG_REJ_HW:    cfg.rej_hw    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = DATA_W'(cfg.threshold);
      REG_ASYMMETRY: prdata = DATA_W'(cfg.asymmetry);
      REG_MAIN_HW:   prdata = DATA_W'(cfg.main_hw);
      REG_REJ_HW:    prdata = DATA_W'(cfg.rej_hw);
      default:       prdata = '0;
    endcase
  end

  sed_window #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
  ) u_window (
    .clk      (clk),
    .shift    (shift),
    .sample   (in_ch.sample),
    .line_max (line_max),
    .line_min (line_min),
    .main_taps(main_taps),
    .min_taps (min_taps)
  );

  sed_sharp u_sharp_main (
    .taps(main_taps),
    .cfg (cfg),
    .pass(main_pass)
  );

  sed_sharp u_sharp_min (
    .taps(min_taps),
    .cfg (cfg),
    .pass(min_pass)
  );

  sed_seq #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg      (cfg),
    .main_pass(main_pass),
    .min_pass (min_pass),
    .shift    (shift),
    .line_max (line_max),
    .line_min (line_min)
  );

  assign last_beat = out_ch.valid && out_ch.last_of_run;

  `SED_ASSERT_ALWAYS(a_width_order, clk, rst, line_min <= line_max, "rejection width above main")
  `SED_ASSERT_IMPL(a_last_is_border, clk, rst, last_beat, !out_ch.extremum, "flag on border beat")
  `SED_ASSERT_NEXT(a_width_latched, clk, rst, shift, line_max != '0, "no half width latched")

endmodule
